/* sv/srq_pkg.sv */
// Package for the sorted reminder queue: entry layout, status codes,
// cell control types and the day-limit check. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [6:0] DAYS_LONG  = 7'd31;
  localparam logic [6:0] DAYS_FEB   = 7'd29;
  localparam logic [6:0] DAYS_SHORT = 7'd30;

  typedef logic [24:0] key_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_BAD_DAY  = 3'd1,
    ST_FULL     = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REQ_INSERT = 1'b0,
    REQ_DUMP   = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   ins;
  } cell_ctrl_t;

  function automatic key_t entry_key(entry_t e);
    return {e.month, e.day, e.hour, e.minute};
  endfunction

  function automatic logic day_ok(logic [3:0] month, logic [6:0] day);
    logic [6:0] limit;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: limit = DAYS_LONG;
      4'd2:                                          limit = DAYS_FEB;
      default:                                       limit = DAYS_SHORT;
    endcase
    return day <= limit;
  endfunction

endpackage

`default_nettype wire

/* sv/srq_req_if.sv */
// Request channel: valid/ready handshake carrying one insert or dump request.
// Standalone; widths follow the entry layout in srq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [15:0] msg_tag;

  modport source (output valid, req_type, month, day, hour, minute, msg_tag,
                  input ready);
  modport sink   (input valid, req_type, month, day, hour, minute, msg_tag,
                  output ready);
endinterface

`default_nettype wire

/* sv/srq_rsp_if.sv */
// Result channel: valid/ready handshake carrying one status or dumped entry.
// Standalone; widths follow the entry layout in srq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  out_month;
  logic [6:0]  out_day;
  logic [6:0]  out_hour;
  logic [6:0]  out_minute;
  logic [15:0] out_tag;
  logic        last;

  modport source (output valid, status, out_month, out_day, out_hour, out_minute,
                  out_tag, last, input ready);
  modport sink   (input valid, status, out_month, out_day, out_hour, out_minute,
                  out_tag, last, output ready);
endinterface

`default_nettype wire

/* sv/srq_cell.sv */
// One slot of the sorted chain: holds an entry, decides keep/take-new/shift on
// insert, and passes entries toward the head on rotate. Depends on srq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srq_cell import srq_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       valid_i,
  input  wire logic       is_tail_i,
  input  wire logic       left_lt_i,
  input  wire entry_t     left_i,
  input  wire entry_t     right_i,
  input  wire entry_t     head_i,
  output entry_t          entry_o,
  output logic            lt_o
);

  entry_t entry_q, entry_d;

  // stored key strictly below the new key: this slot keeps its entry
  assign lt_o    = valid_i && (entry_key(entry_q) < entry_key(ctrl_i.ins));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (lt_o)           entry_d = entry_q;
        else if (left_lt_i) entry_d = ctrl_i.ins;
        else                entry_d = left_i;
      end
      CELL_ROTATE: begin
        entry_d = is_tail_i ? head_i : right_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

/* sv/sorted_reminder_queue.sv */
// Sorted reminder queue: an insert/reject is accepted on the handshake, its result
// registered the next cycle; a dump of n entries streams one entry per cycle from the
// head cell while the chain rotates and the result channel is ready, n results, next
// request taken after the last one leaves. One insert per cycle while results are taken.
// Reset clears the entry count, the output register and the controller; cell
// contents are not reset. Depends on srq_pkg, srq_req_if, srq_rsp_if, srq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_reminder_queue import srq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srq_req_if.sink   req_i,
  srq_rsp_if.source rsp_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  logic             out_valid_q;
  status_e          status_q;
  entry_t           out_q;
  logic             last_q;

  entry_t     cell_entry [CAPACITY];
  logic       cell_lt    [CAPACITY];
  cell_ctrl_t ctrl;
  entry_t     new_entry;

  logic out_free, acc, full, ins_ok;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign acc = req_i.valid && req_i.ready;
  assign full = (count_q == CNT_W'(CAPACITY));
  assign ins_ok = acc && (req_i.req_type == REQ_INSERT) && !full &&
                  day_ok(req_i.month, req_i.day);

  assign new_entry = '{month: req_i.month, day: req_i.day, hour: req_i.hour,
                       minute: req_i.minute, tag: req_i.msg_tag};

  always_comb begin
    ctrl.ins = new_entry;
    if (ins_ok)                             ctrl.op = CELL_INSERT;
    else if (state_q == S_DUMP && out_free) ctrl.op = CELL_ROTATE;
    else                                    ctrl.op = CELL_HOLD;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i + 1) % CAPACITY;
    srq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (CNT_W'(i) < count_q),
      .is_tail_i (count_q == CNT_W'(i + 1)),
      .left_lt_i ((i == 0) ? 1'b1 : cell_lt[LEFT]),
      .left_i    (cell_entry[LEFT]),
      .right_i   (cell_entry[RIGHT]),
      .head_i    (cell_entry[0]),
      .entry_o   (cell_entry[i]),
      .lt_o      (cell_lt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_INSERTED;
      out_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            out_q  <= '0;
            last_q <= 1'b1;
            if (req_i.req_type == REQ_DUMP) begin
              if (count_q == '0) begin
                out_valid_q <= 1'b1;
                status_q    <= ST_EMPTY;
              end else begin
                state_q <= S_DUMP;
                idx_q   <= '0;
              end
            end else begin
              out_valid_q <= 1'b1;
              if (full)        status_q <= ST_FULL;
              else if (ins_ok) status_q <= ST_INSERTED;
              else             status_q <= ST_BAD_DAY;
              if (ins_ok) count_q <= count_q + CNT_W'(1);
            end
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ST_ENTRY;
            out_q       <= cell_entry[0];
            last_q      <= (idx_q == count_q - CNT_W'(1));
            idx_q       <= idx_q + CNT_W'(1);
            if (idx_q == count_q - CNT_W'(1)) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.out_month  = out_q.month;
  assign rsp_o.out_day    = out_q.day;
  assign rsp_o.out_hour   = out_q.hour;
  assign rsp_o.out_minute = out_q.minute;
  assign rsp_o.out_tag    = out_q.tag;
  assign rsp_o.last       = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> (count_q != '0) && (idx_q < count_q))
    else $error("dump index out of range");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not bump the count");

  a_dump_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> count_q == $past(count_q))
    else $error("count changed during dump");

endmodule

`default_nettype wire
